// ----- rtl/core/tgt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_pkg: shared types and constants for the text grid terminal core
// Field widths, control byte codes, mode codes and the word structs that
// pass between the sequencer and the top level.
// ----------------------------------------------------------------------------
package tgt_pkg;

  localparam int BYTE_W = 8;
  localparam int ROW_FW = 5;
  localparam int COL_FW = 6;

  // mode codes
  localparam logic MODE_FEED = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // control bytes
  localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'd127;

  // one input word
  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] byte_in;
    logic [ROW_FW-1:0] read_row;
    logic [COL_FW-1:0] read_col;
  } item_t;

  // one result word
  typedef struct packed {
    logic [BYTE_W-1:0] cell_value;
    logic [ROW_FW-1:0] cursor_row;
    logic [COL_FW-1:0] cursor_col;
  } res_t;

endpackage

// ----- rtl/core/tgt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1408,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/tgt_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_alu: shared modular row adder
// Computes (a + b) mod GRID_ROWS with one add and one compare-subtract;
// inputs are known to stay below GRID_ROWS.
// ----------------------------------------------------------------------------
module tgt_alu #(
  parameter int GRID_ROWS = 22,
  localparam int RW = $clog2(GRID_ROWS)
) (
  input  logic [RW-1:0] a_i,
  input  logic [RW-1:0] b_i,
  output logic [RW-1:0] y_o
);

  localparam logic [RW:0] MOD = (RW+1)'(GRID_ROWS);

  logic [RW:0] sum;

  always_comb begin
    sum = {1'b0, a_i} + {1'b0, b_i};
    if (sum >= MOD) begin
      y_o = RW'(sum - MOD);
    end else begin
      y_o = RW'(sum);
    end
  end

endmodule

// ----- rtl/core/tgt_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_seq: byte render sequencer
// Holds cursor, ring offset and tab phase; walks each word through the
// grid RAM with at most one access per cycle, sharing one modular row adder.
// ----------------------------------------------------------------------------
module tgt_seq #(
  parameter int GRID_ROWS = 22,
  parameter int GRID_COLS = 56,
  parameter int TAB_WIDTH = 4,
  localparam int RW = $clog2(GRID_ROWS),
  localparam int CW = $clog2(GRID_COLS),
  localparam int AW = RW + CW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  tgt_pkg::item_t                item_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output tgt_pkg::res_t                 res_o,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [tgt_pkg::BYTE_W-1:0]    mem_wdata_o,
  output logic                          mem_re_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [tgt_pkg::BYTE_W-1:0]    mem_rdata_i
);

  import tgt_pkg::*;

  localparam int PW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

  localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);
  localparam logic [PW-1:0] TAB_LAST = PW'(TAB_WIDTH - 1);
  localparam logic [AW-1:0] MEM_LAST = AW'(GRID_ROWS * (2 ** CW) - 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_RDD  = 4'd3;
  localparam logic [3:0] S_NL   = 4'd4;
  localparam logic [3:0] S_SCR  = 4'd5;
  localparam logic [3:0] S_PR   = 4'd6;
  localparam logic [3:0] S_PRW  = 4'd7;
  localparam logic [3:0] S_PRZ  = 4'd8;
  localparam logic [3:0] S_BS   = 4'd9;
  localparam logic [3:0] S_TAB  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]        state_q, state_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     top_q, top_d;
  logic [PW-1:0]     ph_q, ph_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [CW-1:0]     sc_q, sc_d;
  logic              ret_q, ret_d;     // newline continues into a print
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [ROW_FW-1:0] rr_q, rr_d;
  logic [COL_FW-1:0] rc_q, rc_d;
  logic [BYTE_W-1:0] cell_q, cell_d;

  logic [RW-1:0]     alu_a, alu_b, alu_y;
  logic [PW-1:0]     ph_inc;

  tgt_alu #(
    .GRID_ROWS(GRID_ROWS)
  ) u_alu (
    .a_i(alu_a),
    .b_i(alu_b),
    .y_o(alu_y)
  );

  assign ph_inc = (ph_q == TAB_LAST) ? '0 : ph_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    top_d       = top_q;
    ph_d        = ph_q;
    clr_d       = clr_q;
    sc_d        = sc_q;
    ret_d       = ret_q;
    byte_d      = byte_q;
    rr_d        = rr_q;
    rc_d        = rc_q;
    cell_d      = cell_q;
    alu_a       = row_q;
    alu_b       = top_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = {alu_y, col_q};
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = {alu_y, CW'(rc_q)};

    unique case (state_q)
      S_CLR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + 1'b1;
        if (clr_q == MEM_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid_i) begin
          byte_d = item_i.byte_in;
          rr_d   = item_i.read_row;
          rc_d   = item_i.read_col;
          cell_d = '0;
          ret_d  = 1'b0;
          if (item_i.mode == MODE_READ) begin
            if (32'(item_i.read_row) < GRID_ROWS && 32'(item_i.read_col) < GRID_COLS) begin
              state_d = S_RD;
            end else begin
              state_d = S_OUT;
            end
          end else begin
            unique case (item_i.byte_in) inside
              CH_CR:          state_d = S_OUT;
              CH_LF:          state_d = S_NL;
              CH_BS, CH_DEL:  state_d = (col_q != '0) ? S_BS : S_OUT;
              CH_TAB:         state_d = S_TAB;
              default:        state_d = S_PR;
            endcase
          end
        end
      end
      S_RD: begin
        alu_a    = RW'(rr_q);
        mem_re_o = 1'b1;
        state_d  = S_RDD;
      end
      S_RDD: begin
        cell_d  = mem_rdata_i;
        state_d = S_OUT;
      end
      S_NL: begin
        if (row_q != ROW_LAST) begin
          row_d   = row_q + 1'b1;
          col_d   = '0;
          ph_d    = '0;
          state_d = ret_q ? S_PRW : S_OUT;
        end else begin
          sc_d    = '0;
          state_d = S_SCR;
        end
      end
      S_SCR: begin
        // wipe the old top row; it becomes the new bottom row
        mem_we_o    = 1'b1;
        mem_waddr_o = {top_q, sc_q};
        sc_d        = sc_q + 1'b1;
        if (sc_q == COL_LAST) begin
          alu_a   = top_q;
          alu_b   = RW'(1);
          top_d   = alu_y;
          col_d   = '0;
          ph_d    = '0;
          state_d = ret_q ? S_PRW : S_OUT;
        end
      end
      S_PR: begin
        if (col_q == COL_LAST) begin
          ret_d   = 1'b1;
          state_d = S_NL;
        end else begin
          state_d = S_PRW;
        end
      end
      S_PRW: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = byte_q;
        col_d       = col_q + 1'b1;
        ph_d        = ph_inc;
        state_d     = S_PRZ;
      end
      S_PRZ: begin
        mem_we_o = 1'b1;
        state_d  = S_OUT;
      end
      S_BS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = {alu_y, col_q - 1'b1};
        col_d       = col_q - 1'b1;
        ph_d        = (ph_q == '0) ? TAB_LAST : ph_q - 1'b1;
        state_d     = S_OUT;
      end
      S_TAB: begin
        if (col_q != COL_LAST) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = CH_SPACE;
          col_d       = col_q + 1'b1;
          ph_d        = ph_inc;
          if (ph_q == TAB_LAST) begin
            state_d = S_OUT;
          end
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      row_q   <= '0;
      col_q   <= '0;
      top_q   <= '0;
      ph_q    <= '0;
      clr_q   <= '0;
      sc_q    <= '0;
      ret_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      top_q   <= top_d;
      ph_q    <= ph_d;
      clr_q   <= clr_d;
      sc_q    <= sc_d;
      ret_q   <= ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    rr_q   <= rr_d;
    rc_q   <= rc_d;
    cell_q <= cell_d;
  end

  assign item_ready_o      = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_OUT);
  assign res_o.cell_value  = cell_q;
  assign res_o.cursor_row  = ROW_FW'(row_q);
  assign res_o.cursor_col  = COL_FW'(col_q);

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we_o)
    else $error("grid written while idle");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("grid read and write in one cycle");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= COL_LAST) && (row_q <= ROW_LAST) && (top_q <= ROW_LAST))
    else $error("cursor or ring offset out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && item_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted word did not start");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |=> !res_valid_o)
    else $error("result offered twice");
`endif

endmodule

// ----- rtl/core/text_grid_terminal_renderer_core.sv -----
// Per word, before the result enters the output register: CR leaves the cursor,
// backspace clears the cell left of the cursor, line feed moves down a row
// (scrolling the grid from the last row), printable writes the byte (wrapping
// first at the last column), tab writes spaces to the next stop, read looks up a cell.
// Throughput: one word at a time, one grid RAM access per cycle sets it.
// Reset: cursor and ring offset go to zero, then all GRID_ROWS * 2**clog2(GRID_COLS)
// grid RAM cells (1408 by default) are cleared, input stalled.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_grid_terminal_renderer_core: character-cell text grid with cursor
// Renders a byte stream into a ring-addressed character grid and reads
// cells back, one word per handshake, one result word per input word.
// ----------------------------------------------------------------------------
module text_grid_terminal_renderer_core #(
  parameter int GRID_ROWS = 22,
  parameter int GRID_COLS = 56,
  parameter int TAB_WIDTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] byte_in, [12:8] read_row, [18:13] read_col
  input  logic        s_axis_tuser,  // [0] mode: 0 feed byte, 1 read cell
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // [7:0] cell_value, [12:8] cursor_row,
                                     // [18:13] cursor_col
);

  import tgt_pkg::*;

  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int AW    = RW + CW;
  // rows are addressed as {physical row, column}; columns pad to a power of two
  localparam int DEPTH = GRID_ROWS * (2 ** CW);

  item_t             item;
  res_t              res;
  logic              res_valid;
  logic              res_ready;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // output register: lets the sequencer finish while the sink stalls
  logic              out_valid_q, out_valid_d;
  res_t              out_res_q;

  assign item.mode     = s_axis_tuser;
  assign item.byte_in  = s_axis_tdata[7:0];
  assign item.read_row = s_axis_tdata[12:8];
  assign item.read_col = s_axis_tdata[18:13];

  tgt_seq #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS),
    .TAB_WIDTH(TAB_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(s_axis_tvalid),
    .item_ready_o(s_axis_tready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // grid store, one byte per cell
  tgt_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // slot is free when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_res_q.cursor_col, out_res_q.cursor_row,
                          out_res_q.cell_value};

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !res_ready)
    else $error("result slot overwritten");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> m_axis_tvalid)
    else $error("loaded result not shown");
`endif

endmodule
